### sv/mnst_pkg.sv
// ----------------------------------------------------------------------------
// mnst_pkg
// Shared types, codes and table generators of the note-on sine tone synth.
// ----------------------------------------------------------------------------
package mnst_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned DEF_SAMPLE_RATE    = 8000;
  localparam int unsigned DEF_PHASE_BITS     = 32;
  localparam int unsigned DEF_SINE_ADDR_BITS = 10;

  localparam int unsigned NOTE_COUNT = 256;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_NOTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BYTE      = 1'd1;

  localparam logic [15:0] RST_SAMPLES_PER_NOTE = 16'd8000;
  localparam logic [7:0]  RST_MARKER_BYTE      = 8'h90;

  // Input opcodes.
  localparam logic [1:0] OP_FILE_BYTE   = 2'd0;
  localparam logic [1:0] OP_SAMPLE_TICK = 2'd1;
  localparam logic [1:0] OP_END_OF_FILE = 2'd2;

  // Command queue between the parser and the tone engine (power-of-two depth).
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_of_note;
  } out_t;

  typedef enum logic [1:0] {
    CMD_NOTE,
    CMD_TICK,
    CMD_STOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] note;
  } cmd_t;

  // Semitone ratios 2^(k/12) in Q16.
  localparam logic [16:0] SEMITONE_Q16 [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam longint      Q30_ONE    = longint'(1) << 30;

  // One Taylor step: term * x^2 in Q30, before the factorial divide.
  function automatic logic [63:0] taylor_step(logic [63:0] t, logic [63:0] x);
    return (((t * x) >> 30) * x) >> 30;
  endfunction

  // Quarter-wave sine in Q30 at table index j, clamped to 0..1.
  function automatic longint quarter_sine(int unsigned j, int unsigned ab);
    logic [63:0] x;
    logic [63:0] t;
    longint      sum;
    x   = (64'(j) * TWO_PI_Q30 + (64'd1 << (ab - 1))) >> ab;
    t   = x;
    sum = longint'(x);
    t = taylor_step(t, x) / 64'd6;   sum = sum - longint'(t);
    t = taylor_step(t, x) / 64'd20;  sum = sum + longint'(t);
    t = taylor_step(t, x) / 64'd42;  sum = sum - longint'(t);
    t = taylor_step(t, x) / 64'd72;  sum = sum + longint'(t);
    t = taylor_step(t, x) / 64'd110; sum = sum - longint'(t);
    t = taylor_step(t, x) / 64'd156; sum = sum + longint'(t);
    t = taylor_step(t, x) / 64'd210; sum = sum - longint'(t);
    t = taylor_step(t, x) / 64'd272; sum = sum + longint'(t);
    t = taylor_step(t, x) / 64'd342; sum = sum - longint'(t);
    t = taylor_step(t, x) / 64'd420; sum = sum + longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    return sum;
  endfunction

  // Full-wave sine table entry k, offset and scaled to floor((sin+2)/3*255).
  function automatic logic [7:0] sine_entry(int unsigned k, int unsigned ab);
    int unsigned quarter;
    int unsigned quad;
    int unsigned j;
    longint      s;
    logic [63:0] u;
    quarter = 1 << (ab - 2);
    quad    = k >> (ab - 2);
    j       = k & (quarter - 1);
    s       = quarter_sine(((quad & 1) != 0) ? quarter - j : j, ab);
    if (quad >= 2) begin
      s = -s;
    end
    u = 64'(s + 2 * Q30_ONE);
    return 8'((u * 64'd85) >> 30);
  endfunction

  // Phase increment of note n, rounded half up, by restoring long division.
  function automatic logic [63:0] inc_entry(int unsigned n, int unsigned sr,
                                            int unsigned pb);
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    int unsigned s;
    a = 64'd81758 * 64'(SEMITONE_Q16[n % 12]);
    d = 64'd10000 * 64'(sr);
    s = n / 12 + pb - 16;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], a[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    for (int unsigned i = 0; i < s; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= d) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

### sv/mnst_front.sv
// ----------------------------------------------------------------------------
// mnst_front
// Byte parser: finds the note-on marker and turns input items into commands.
// ----------------------------------------------------------------------------
module mnst_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [mnst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mnst_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mnst_pkg::in_t                    in_data_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output mnst_pkg::cmd_t                   cmd_o
);
  import mnst_pkg::*;

  logic       expect_q, expect_d;
  logic [7:0] marker_q;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_TICK;
    cmd_o.note  = in_data_i.data_byte;
    expect_d    = expect_q;
    if (accept) begin
      unique case (in_data_i.opcode)
        OP_FILE_BYTE: begin
          // The byte after a marker is always the note, even if it is a marker.
          if (expect_q) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_NOTE;
            expect_d   = 1'b0;
          end else if (in_data_i.data_byte == marker_q) begin
            expect_d = 1'b1;
          end
        end
        OP_SAMPLE_TICK: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_TICK;
        end
        OP_END_OF_FILE: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_STOP;
          expect_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b0;
      marker_q <= RST_MARKER_BYTE;
    end else begin
      expect_q <= expect_d;
      if (cfg_valid_i && cfg_index_i == CFG_MARKER_BYTE) begin
        marker_q <= cfg_data_i[7:0];
      end
    end
  end

endmodule

### sv/mnst_queue.sv
// ----------------------------------------------------------------------------
// mnst_queue
// Small command FIFO between the parser and the tone engine.
// ----------------------------------------------------------------------------
module mnst_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mnst_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mnst_pkg::cmd_t pop_data_o
);
  import mnst_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o     = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
    else $error("command queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from an empty queue");

endmodule

### sv/mnst_back.sv
// ----------------------------------------------------------------------------
// mnst_back
// Tone engine: phase accumulator, sample counter and sine table lookup.
// ----------------------------------------------------------------------------
module mnst_back #(
  parameter int unsigned SAMPLE_RATE    = mnst_pkg::DEF_SAMPLE_RATE,
  parameter int unsigned PHASE_BITS     = mnst_pkg::DEF_PHASE_BITS,
  parameter int unsigned SINE_ADDR_BITS = mnst_pkg::DEF_SINE_ADDR_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [mnst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mnst_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             q_empty_i,
  input  mnst_pkg::cmd_t                   cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mnst_pkg::out_t                   out_data_o
);
  import mnst_pkg::*;

  localparam int unsigned SINE_SIZE = 1 << SINE_ADDR_BITS;

  logic [7:0]            sine_rom [SINE_SIZE];
  logic [PHASE_BITS-1:0] inc_rom  [NOTE_COUNT];

  for (genvar gk = 0; gk < SINE_SIZE; gk++) begin : g_sine
    localparam logic [7:0] SINE_VAL = sine_entry(gk, SINE_ADDR_BITS);
    assign sine_rom[gk] = SINE_VAL;
  end

  for (genvar gn = 0; gn < NOTE_COUNT; gn++) begin : g_inc
    localparam logic [63:0] INC_FULL = inc_entry(gn, SAMPLE_RATE, PHASE_BITS);
    assign inc_rom[gn] = INC_FULL[PHASE_BITS-1:0];
  end

  logic                      active_q, active_d;
  logic [15:0]               done_q, done_d;
  logic [15:0]               spn_q;
  logic [PHASE_BITS-1:0]     phase_q, phase_d;
  logic [PHASE_BITS-1:0]     inc_q, inc_d;
  logic                      out_valid_q;
  logic [7:0]                sample_q;
  logic                      last_q;
  logic                      out_ready;
  logic                      produce;
  logic [15:0]               done_inc;
  logic                      last;
  logic [SINE_ADDR_BITS-1:0] addr;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign pop_o     = !q_empty_i && out_ready;
  assign produce   = pop_o && (cmd_i.kind == CMD_TICK) && active_q;
  assign done_inc  = done_q + 16'd1;
  assign last      = (done_inc == spn_q);
  assign addr      = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];

  always_comb begin
    active_d = active_q;
    done_d   = done_q;
    phase_d  = phase_q;
    inc_d    = inc_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        CMD_NOTE: begin
          active_d = 1'b1;
          done_d   = '0;
          phase_d  = '0;
          inc_d    = inc_rom[cmd_i.note];
        end
        CMD_TICK: begin
          if (active_q) begin
            done_d   = done_inc;
            phase_d  = phase_q + inc_q;
            active_d = !last;
          end
        end
        CMD_STOP: active_d = 1'b0;
        default: ;
      endcase
    end
  end

  // Registered table read doubles as the output register.
  always_ff @(posedge clk_i) begin
    if (produce) begin
      sample_q <= sine_rom[addr];
      last_q   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      done_q      <= '0;
      phase_q     <= '0;
      inc_q       <= '0;
      spn_q       <= RST_SAMPLES_PER_NOTE;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      phase_q  <= phase_d;
      inc_q    <= inc_d;
      if (out_ready) begin
        out_valid_q <= produce;
      end
      if (cfg_valid_i && cfg_index_i == CFG_SAMPLES_PER_NOTE) begin
        spn_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.sample       = sample_q;
  assign out_data_o.last_of_note = last_q;

  a_note_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == CMD_NOTE) |=> (active_q && done_q == '0 && phase_q == '0))
    else $error("a new note did not restart play");

  a_last_ends_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && last) |=> (!active_q && out_valid_q && last_q))
    else $error("last sample did not end the note");

  a_silent_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == CMD_TICK && !active_q) |=> !out_valid_q)
    else $error("a tick while silent produced a sample");

endmodule

### sv/midi_note_sine_tone_synth.sv
// ----------------------------------------------------------------------------
// midi_note_sine_tone_synth
// Note-on sine tone synthesizer built on direct digital synthesis.
// ----------------------------------------------------------------------------
// The input channel carries file bytes, sample ticks and an end-of-file mark.
// A byte after the note-on marker starts a note; each tick during a note
// returns one 8-bit sample on the output channel, the last one of the note
// flagged. Other items return nothing.
// The block takes one item per cycle while in_stall_o is low. An accepted
// tick is written into the command queue; when the tone engine pops it, the
// registered sine table read, which also serves as the output register,
// loads the sample and raises out_valid_o for the receiver.
// The configuration channel is always ready and sets the note length and the
// marker byte; write it only while the block is idle.
// Reset clears the parser and silences play; the note length returns to 8000
// samples and the marker to 0x90. No clearing pass is needed.
// While the receiver stalls a valid sample, the output transaction holds and the tone engine
// stops taking commands; the two-entry queue then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module midi_note_sine_tone_synth #(
  parameter int unsigned SAMPLE_RATE    = mnst_pkg::DEF_SAMPLE_RATE,
  parameter int unsigned PHASE_BITS     = mnst_pkg::DEF_PHASE_BITS,
  parameter int unsigned SINE_ADDR_BITS = mnst_pkg::DEF_SINE_ADDR_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mnst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mnst_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mnst_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mnst_pkg::out_t                   out_data_o
);
  import mnst_pkg::*;

  logic cfg_write;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  mnst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_write),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  mnst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_cmd)
  );

  mnst_back #(
    .SAMPLE_RATE    (SAMPLE_RATE),
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_write),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/midi_note_sine_tone_synth_test.sv
// ----------------------------------------------------------------------------
// midi_note_sine_tone_synth_test
// Self-checking bench for the note-on sine tone synthesizer. A short table of
// directed rows covers the special cases. Phases of random file bytes, ticks
// and end-of-file marks follow, each under its own note length and marker.
// The expected samples come from a local predictor with its own sine and
// phase-increment tables, or from the table itself for some directed rows.
// ----------------------------------------------------------------------------
module midi_note_sine_tone_synth_test;
  import mnst_pkg::*;

  localparam int unsigned SAMPLE_RATE    = DEF_SAMPLE_RATE;
  localparam int unsigned PHASE_BITS     = DEF_PHASE_BITS;
  localparam int unsigned SINE_ADDR_BITS = DEF_SINE_ADDR_BITS;
  localparam int unsigned SINE_ENTRIES   = 1 << SINE_ADDR_BITS;
  localparam int unsigned QUARTER_WAVE   = SINE_ENTRIES / 4;
  localparam logic [63:0] PHASE_MASK     = (64'd1 << PHASE_BITS) - 64'd1;
  localparam logic [63:0] TURN_Q30       = 64'd6746518852;
  localparam longint      UNIT_Q30       = longint'(1) << 30;

  // The unused opcode must be ignored by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Phase zero sits at mid-scale of the offset sine.
  localparam logic [7:0] MID_SAMPLE = 8'd170;

  localparam int unsigned IDLE_SETTLE  = 4;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 112;
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [16:0] RATIO_Q16 [12] = '{
    17'd65536,  17'd69433,  17'd73562,  17'd77936,
    17'd82570,  17'd87480,  17'd92682,  17'd98193,
    17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef enum logic [1:0] {ROW_ITEM, ROW_LENGTH, ROW_MARKER} row_kind_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_TYPED} row_check_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic [1:0]  opcode;
    logic [7:0]  data;
    row_check_e  check;
    logic [7:0]  sample;
    logic        last_flag;
  } row_t;

  localparam int unsigned PLAN_ROWS = 35;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h90, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h90, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_TYPED,   MID_SAMPLE, 1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'hFF, CHK_PREDICT, 8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h90, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_TYPED,   MID_SAMPLE, 1'b0},
    '{ROW_ITEM,   16'd0,     OP_UNUSED,      8'hFF, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_PREDICT, 8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_END_OF_FILE, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h90, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_END_OF_FILE, 8'hFF, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h05, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_LENGTH, 16'd1,     OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h90, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'hFF, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_TYPED,   MID_SAMPLE, 1'b1},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_MARKER, 16'hFF00,  OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_LENGTH, 16'd2,     OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'h7F, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_PREDICT, 8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_PREDICT, 8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_LENGTH, 16'd0,     OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_MARKER, 16'h00FF,  OP_FILE_BYTE,   8'h00, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'hFF, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_FILE_BYTE,   8'hFF, CHK_SILENT,  8'd0,       1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_TYPED,   MID_SAMPLE, 1'b0},
    '{ROW_ITEM,   16'd0,     OP_SAMPLE_TICK, 8'h00, CHK_PREDICT, 8'd0,       1'b0},
    '{ROW_LENGTH, 16'hFFFF,  OP_END_OF_FILE, 8'h00, CHK_SILENT,  8'd0,       1'b0}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;

  midi_note_sine_tone_synth u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor tables and state.
  logic [7:0]            sine_tab [SINE_ENTRIES];
  logic [PHASE_BITS-1:0] step_tab [NOTE_COUNT];
  logic [15:0]           len_reg    = RST_SAMPLES_PER_NOTE;
  logic [7:0]            marker_reg = RST_MARKER_BYTE;
  bit                    want_note  = 1'b0;
  logic [7:0]            tone_note  = '0;
  logic [PHASE_BITS-1:0] tone_phase = '0;
  logic [15:0]           tone_count = '0;
  bit                    tone_on    = 1'b0;

  out_t        pending_samples [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          tx_calm    = 1'b0;
  bit          rx_calm    = 1'b0;
  int unsigned stall_left = 0;

  // Quarter-wave sine in Q30 from an eleven-term Taylor series, clamped to 0..1.
  function automatic longint quarter_sin(int unsigned j);
    logic [63:0] x;
    logic [63:0] t;
    longint      acc;
    x   = (64'(j) * TURN_Q30 + (64'd1 << (SINE_ADDR_BITS - 1))) >> SINE_ADDR_BITS;
    t   = x;
    acc = longint'(x);
    for (int unsigned i = 1; i <= 10; i++) begin
      t = (((t * x) >> 30) * x) >> 30;
      t = t / (64'(2 * i) * 64'(2 * i + 1));
      if ((i % 2) == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > UNIT_Q30) begin
      acc = UNIT_Q30;
    end
    return acc;
  endfunction

  // Phase step of note n: the note frequency over the sample rate, rounded
  // half up, as a fraction of one turn of the accumulator.
  function automatic logic [PHASE_BITS-1:0] note_step(int unsigned n);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] r;
    int unsigned shifts;
    num    = 64'd81758 * 64'(RATIO_Q16[n % 12]);
    den    = 64'd10000 * 64'(SAMPLE_RATE);
    shifts = n / 12 + PHASE_BITS - 16;
    q      = num / den;
    r      = num % den;
    for (int unsigned i = 0; i < shifts; i++) begin
      r = r << 1;
      q = (q << 1) & PHASE_MASK;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= den) begin
      q = q + 64'd1;
    end
    return q[PHASE_BITS-1:0];
  endfunction

  function automatic in_t make_item(logic [1:0] op, logic [7:0] b);
    in_t it;
    it.opcode    = op;
    it.data_byte = b;
    return it;
  endfunction

  // Advances the predicted synth state by one input transaction.
  task automatic next_sample(input in_t it, output bit fires, output out_t res);
    fires = 1'b0;
    res   = '0;
    case (it.opcode)
      OP_FILE_BYTE: begin
        if (want_note) begin
          tone_note  = it.data_byte;
          tone_phase = '0;
          tone_count = '0;
          tone_on    = 1'b1;
          want_note  = 1'b0;
        end else if (it.data_byte == marker_reg) begin
          want_note = 1'b1;
        end
      end
      OP_SAMPLE_TICK: begin
        if (tone_on) begin
          fires            = 1'b1;
          res.sample       = sine_tab[tone_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
          tone_count       = tone_count + 16'd1;
          res.last_of_note = (tone_count == len_reg);
          if (res.last_of_note) begin
            tone_on = 1'b0;
          end
          tone_phase = tone_phase + step_tab[tone_note];
        end
      end
      OP_END_OF_FILE: begin
        tone_on   = 1'b0;
        want_note = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
  endtask

  task automatic send_item(input in_t item, input row_check_e chk = CHK_PREDICT,
                           input out_t typed = '0);
    out_t res;
    bit   fires;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_sample(item, fires, res);
    if (chk == CHK_TYPED) begin
      pending_samples.push_back(typed);
    end else if (chk == CHK_PREDICT && fires) begin
      pending_samples.push_back(res);
    end
    @(negedge clk_i);
  endtask

  // Holds off the sender until every expected sample is out and the
  // pipeline has had time to absorb transactions that give no sample.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (IDLE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_SAMPLES_PER_NOTE) begin
      len_reg = value;
    end else begin
      marker_reg = value[7:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 6))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd0;
      3: return 16'hFFFF;
      4: return RST_SAMPLES_PER_NOTE;
      default: return 16'($urandom_range(3, 40));
    endcase
  endfunction

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return RST_MARKER_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver stalls come in bursts, each started at random and held while stall_left counts down.
  always @(negedge clk_i) begin
    if (rx_calm) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected sample %0d last %0d",
                                out_data_o.sample, out_data_o.last_of_note));
      end else begin
        if (out_data_o.sample !== pending_samples[0].sample) begin
          flag_mismatch($sformatf("sample expected %0d, got %0d",
                                  pending_samples[0].sample, out_data_o.sample));
        end
        if (out_data_o.last_of_note !== pending_samples[0].last_of_note) begin
          flag_mismatch($sformatf("last_of_note expected %0d, got %0d",
                                  pending_samples[0].last_of_note,
                                  out_data_o.last_of_note));
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL midi_note_sine_tone_synth");
      $finish;
    end
  end

  initial begin
    out_t        typed;
    int unsigned sent;
    int unsigned pick;
    int unsigned waited;
    int unsigned quad;
    int unsigned j;
    longint      s;
    logic [63:0] u;

    for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
      quad = k / QUARTER_WAVE;
      j    = k % QUARTER_WAVE;
      s    = quarter_sin(((quad % 2) == 1) ? QUARTER_WAVE - j : j);
      if (quad >= 2) begin
        s = -s;
      end
      u           = 64'(s + 2 * UNIT_Q30);
      u           = (u * 64'd85) >> 30;
      sine_tab[k] = u[7:0];
    end
    for (int unsigned n = 0; n < NOTE_COUNT; n++) begin
      step_tab[n] = note_step(n);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      case (PLAN[r].kind)
        ROW_LENGTH: begin
          wait_idle();
          write_reg(CFG_SAMPLES_PER_NOTE, PLAN[r].value);
        end
        ROW_MARKER: begin
          wait_idle();
          write_reg(CFG_MARKER_BYTE, PLAN[r].value);
        end
        default: begin
          typed.sample       = PLAN[r].sample;
          typed.last_of_note = PLAN[r].last_flag;
          send_item(make_item(PLAN[r].opcode, PLAN[r].data), PLAN[r].check, typed);
        end
      endcase
    end

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(CFG_SAMPLES_PER_NOTE, pick_length());
      write_reg(CFG_MARKER_BYTE, {8'($urandom_range(0, 255)), pick_marker()});
      tx_calm = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      rx_calm = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
          // A well-formed note-on followed by a run of ticks.
          send_item(make_item(OP_FILE_BYTE, marker_reg));
          send_item(make_item(OP_FILE_BYTE, 8'($urandom_range(0, 255))));
          sent += 2;
          repeat ($urandom_range(1, 24)) begin
            send_item(make_item(OP_SAMPLE_TICK, 8'($urandom_range(0, 255))));
            sent++;
          end
        end else if (pick < 60) begin
          send_item(make_item(OP_SAMPLE_TICK, 8'($urandom_range(0, 255))));
          sent++;
        end else if (pick < 78) begin
          send_item(make_item(OP_FILE_BYTE, 8'($urandom_range(0, 255))));
          sent++;
        end else if (pick < 84) begin
          send_item(make_item(OP_END_OF_FILE, 8'($urandom_range(0, 255))));
          sent++;
        end else if (pick < 88) begin
          send_item(make_item(OP_UNUSED, 8'($urandom_range(0, 255))));
        end else if (pick < 95) begin
          // A marker followed by a tick or an end of file; only the end of file cancels it.
          send_item(make_item(OP_FILE_BYTE, marker_reg));
          send_item(make_item(($urandom_range(0, 1) == 0) ? OP_SAMPLE_TICK
                                                          : OP_END_OF_FILE,
                              8'($urandom_range(0, 255))));
          sent += 2;
        end else if (pick < 97) begin
          wait_idle();
        end else begin
          send_item(make_item(OP_SAMPLE_TICK, 8'($urandom_range(0, 255))));
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_samples.size() != 0) begin
      flag_mismatch($sformatf("%0d expected samples never arrived",
                              pending_samples.size()));
    end

    if (mismatches == 0) begin
      $display("PASS midi_note_sine_tone_synth");
    end else begin
      $display("FAIL midi_note_sine_tone_synth");
    end
    $finish;
  end

endmodule
